[rtl/kesm_pkg.sv]
// Shared types and constants for the key escape sequence matcher.
// No dependencies; imported by every module of the block but kesm_ram.
package kesm_pkg;

    // Input command codes (stream tuser)
    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_WBYTE = 2'd2,
        CMD_WHDR  = 2'd3
    } t_cmd;

    // Result kinds (stream tuser)
    typedef enum logic [1:0] {
        KIND_RAW   = 2'd0,
        KIND_CODE  = 2'd1,
        KIND_UNDEF = 2'd2,
        KIND_NULL  = 2'd3
    } t_kind;

    // Matcher phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_WAIT    = 2'd2,
        PH_DROP    = 2'd3
    } t_phase;

    // Configuration register indexes
    localparam logic CFG_WAIT_TICKS = 1'b0;
    localparam logic CFG_GW_TICKS   = 1'b1;

    localparam logic [15:0] WAIT_TICKS_RST = 16'd10;
    localparam logic [15:0] GW_TICKS_RST   = 16'd50;
    localparam logic [15:0] TICK_MAX       = 16'hFFFF;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // One queued input word with its classification
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        logic [6:0]  entry_index;
        logic [2:0]  byte_index;
        logic [3:0]  entry_length;
        logic [15:0] entry_code;
        logic        ent_ok;
        logic        pos_ok;
    } t_item;

    // Outcome of one table scan
    typedef struct packed {
        logic [1:0] exact;
        logic       partial;
    } t_scan_flags;

endpackage

[rtl/key_escape_sequence_matcher_core.sv]
// Top level of the key escape sequence matcher.
// Depends on kesm_pkg, kesm_front and kesm_back.
//
//  channel   dir  handshake          payload
//  s (in)    in   i_s_tvalid/o_s_tready  tdata: data_byte, entry_index, byte_index,
//                                        entry_length, entry_code; tuser: command
//  m (out)   out  o_m_tvalid/i_m_tready  tdata: value; tuser: kind; tlast: last
//  cfg       in   i_cfg_we            i_cfg_idx, i_cfg_data
//
// A key byte costs one or two full table scans plus the sequencing states that
// lead to and follow them; a replayed byte or a garbage-window check adds a
// scan. Table writes and plain ticks need no scan; a timeout tick needs none
// either, save the scans of a replayed byte. The single table read port
// walked by the scan unit sets these costs.
// Reset is synchronous and clears all table valid bits at once.
// A two-word input queue and a four-word result queue let each side stall.
module key_escape_sequence_matcher_core
    import kesm_pkg::*;
#(
    parameter int ENTRIES     = 128,
    parameter int MAX_SEQ_LEN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [7:0] data_byte, [14:8] entry_index, [17:15] byte_index,
    // [21:18] entry_length, [37:22] entry_code, [39:38] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] command
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] value
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] kind
    output logic [1:0]            o_m_tuser,
    output logic                  o_m_tlast,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    logic  w_valid;
    logic  w_take;
    t_item w_item;

    kesm_front #(.ENTRIES(ENTRIES), .MAX_SEQ_LEN(MAX_SEQ_LEN)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_tuser  (i_s_tuser),
        .o_valid  (w_valid),
        .o_item   (w_item),
        .i_take   (w_take)
    );

    kesm_back #(.ENTRIES(ENTRIES), .MAX_SEQ_LEN(MAX_SEQ_LEN)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_tdata    (o_m_tdata),
        .o_tuser    (o_m_tuser),
        .o_tlast    (o_m_tlast)
    );
endmodule

[rtl/kesm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kesm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/kesm_front.sv]
// Front end: accepts input words, classifies them and queues two deep.
// Depends on kesm_pkg.
module kesm_front
    import kesm_pkg::*;
#(
    parameter int ENTRIES     = 128,
    parameter int MAX_SEQ_LEN = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [IN_DATA_W-1:0] i_tdata,
    input  logic [1:0]           i_tuser,
    output logic                 o_valid,
    output t_item                o_item,
    input  logic                 i_take
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_in;
    logic       w_push;

    // Unpack and classify the incoming word
    always_comb begin
        w_in.cmd          = t_cmd'(i_tuser);
        w_in.data_byte    = i_tdata[7:0];
        w_in.entry_index  = i_tdata[14:8];
        w_in.byte_index   = i_tdata[17:15];
        w_in.entry_length = i_tdata[21:18];
        w_in.entry_code   = i_tdata[37:22];
        w_in.ent_ok       = 32'(i_tdata[14:8]) < ENTRIES;
        w_in.pos_ok       = 32'(i_tdata[17:15]) < MAX_SEQ_LEN;
    end

    assign o_tready = (r_cnt != 2'd2);
    assign w_push   = i_tvalid && o_tready;
    assign o_valid  = (r_cnt != 2'd0);
    assign o_item   = r_mem[r_rp];

    // Hold up to two words until the back end takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= w_in;
                r_wp        <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_take);
        end
    end
endmodule

[rtl/kesm_scan.sv]
// Table scan unit: walks all entries one per cycle and compares a row.
// Depends on kesm_pkg; table RAMs live in the back end.
module kesm_scan
    import kesm_pkg::*;
#(
    parameter int ENTRIES     = 128,
    parameter int MAX_SEQ_LEN = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [$clog2(MAX_SEQ_LEN+2)-1:0]    i_len,
    input  logic [MAX_SEQ_LEN-1:0][7:0]         i_buf,
    output logic [$clog2(ENTRIES)-1:0]          o_raddr,
    input  logic [$clog2(MAX_SEQ_LEN+1)-1:0]    i_row_len,
    input  logic [MAX_SEQ_LEN-1:0][7:0]         i_row_bytes,
    output logic                                o_done,
    output t_scan_flags                         o_flags,
    output logic [$clog2(ENTRIES)-1:0]          o_hit
);
    localparam int AW = $clog2(ENTRIES);
    localparam int SW = $clog2(MAX_SEQ_LEN + 2);

    logic                          r_run;
    logic [AW-1:0]                 r_addr;
    logic                          r_chk;
    logic [AW-1:0]                 r_chk_idx;
    logic [SW-1:0]                 r_len;
    logic [MAX_SEQ_LEN-1:0][7:0]   r_buf;
    logic                          w_same;
    logic                          w_match;
    logic [SW-1:0]                 w_row_len;

    assign o_raddr   = r_addr;
    assign w_row_len = SW'(i_row_len);

    // Compare the row that arrived from the RAMs this cycle
    always_comb begin
        w_same = 1'b1;
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            if (SW'(i) < r_len && i_row_bytes[i] != r_buf[i]) begin
                w_same = 1'b0;
            end
        end
        w_match = (w_row_len != '0) && (r_len <= w_row_len) && w_same;
    end

    // Advance the address, accumulate match flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_chk  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_chk && (r_chk_idx == AW'(ENTRIES - 1));
            r_chk  <= r_run;
            r_chk_idx <= r_addr;
            if (i_start) begin
                r_run   <= 1'b1;
                r_addr  <= '0;
                r_len   <= i_len;
                r_buf   <= i_buf;
                o_flags <= '0;
                o_hit   <= '0;
            end else if (r_run) begin
                r_addr <= r_addr + AW'(1);
                if (r_addr == AW'(ENTRIES - 1)) begin
                    r_run <= 1'b0;
                end
            end
            if (r_chk && w_match) begin
                if (r_len == w_row_len) begin
                    if (o_flags.exact != 2'd2) begin
                        o_flags.exact <= o_flags.exact + 2'd1;
                    end
                    o_hit <= r_chk_idx;
                end else begin
                    o_flags.partial <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/kesm_back.sv]
// Back end: key table, matching sequencer and result queue.
// Depends on kesm_pkg, kesm_ram and kesm_scan.
module kesm_back
    import kesm_pkg::*;
#(
    parameter int ENTRIES     = 128,
    parameter int MAX_SEQ_LEN = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_item                 i_item,
    output logic                  o_take,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [OUT_DATA_W-1:0] o_tdata,
    output logic [1:0]            o_tuser,
    output logic                  o_tlast
);
    localparam int AW = $clog2(ENTRIES);
    localparam int LW = $clog2(MAX_SEQ_LEN + 1);
    localparam int SW = $clog2(MAX_SEQ_LEN + 2);
    localparam int IW = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;

    typedef enum logic [7:0] {
        S_FETCH = 8'b00000001,
        S_IDLEB = 8'b00000010,
        S_EVAL  = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_CODE  = 8'b00010000,
        S_CODE2 = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_PUSH  = 8'b10000000
    } t_state;

    t_state                      r_state;
    t_phase                      r_phase;
    logic [LW-1:0]               r_mc;
    logic [MAX_SEQ_LEN-1:0][7:0] r_buf;
    logic [15:0]                 r_timer;
    logic [15:0]                 r_pend_code;
    logic                        r_pend_single;
    logic [MAX_SEQ_LEN-1:0][7:0] r_stale;
    logic [LW-1:0]               r_stale_len;
    logic [15:0]                 r_age;
    logic                        r_stale_act;
    logic [15:0]                 r_wait_ticks;
    logic [15:0]                 r_gw_ticks;
    logic [7:0]                  r_cur;
    logic                        r_ctx_stale;
    logic                        r_code_wait;
    logic                        r_fin_single;
    logic [15:0]                 r_fin_code;
    t_kind                       r_res_kind [2];
    logic [15:0]                 r_res_val [2];
    logic [1:0]                  r_res_n;
    logic                        r_push_i;
    logic [ENTRIES-1:0]          r_valid;
    logic                        r_vld_rd;
    t_kind                       r_q_kind [4];
    logic [15:0]                 r_q_val [4];
    logic                        r_q_last [4];
    logic [1:0]                  r_q_wp;
    logic [1:0]                  r_q_rp;
    logic [2:0]                  r_q_cnt;

    logic                        w_take;
    logic                        w_wbyte;
    logic                        w_whdr;
    logic [AW-1:0]               w_waddr;
    logic [LW-1:0]               w_len_sat;
    logic [AW-1:0]               w_raddr;
    logic [AW-1:0]               w_scan_addr;
    logic [LW-1:0]               w_len_rd;
    logic [15:0]                 w_code_rd;
    logic [MAX_SEQ_LEN-1:0][7:0] w_row_bytes;
    logic [LW-1:0]               w_row_len;
    logic                        w_scan_start;
    logic [SW-1:0]               w_scan_len;
    logic [MAX_SEQ_LEN-1:0][7:0] w_scan_buf;
    logic                        w_scan_done;
    t_scan_flags                 w_flags;
    logic [AW-1:0]               w_hit;
    logic                        w_push;
    logic                        w_pop;
    logic                        w_push_last;
    logic [15:0]                 n_age;
    logic [15:0]                 n_timer;

    // Table write decode
    assign w_take  = (r_state == S_FETCH) && i_valid && (r_q_cnt <= 3'd2);
    assign o_take  = w_take;
    assign w_wbyte = w_take && (i_item.cmd == CMD_WBYTE) && i_item.ent_ok && i_item.pos_ok;
    assign w_whdr  = w_take && (i_item.cmd == CMD_WHDR) && i_item.ent_ok;
    assign w_waddr = AW'(i_item.entry_index);
    assign w_len_sat = (32'(i_item.entry_length) > MAX_SEQ_LEN) ? LW'(MAX_SEQ_LEN)
                                                                : LW'(i_item.entry_length);
    assign w_raddr   = (r_state == S_CODE) ? w_hit : w_scan_addr;
    assign w_row_len = r_vld_rd ? w_len_rd : '0;

    // One byte lane RAM per sequence position
    for (genvar g = 0; g < MAX_SEQ_LEN; g++) begin : g_lane
        kesm_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_lane (
            .i_clk   (i_clk),
            .i_we    (w_wbyte && (32'(i_item.byte_index) == g)),
            .i_waddr (w_waddr),
            .i_wdata (i_item.data_byte),
            .i_raddr (w_raddr),
            .o_rdata (w_row_bytes[g])
        );
    end

    kesm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_len (
        .i_clk   (i_clk),
        .i_we    (w_whdr),
        .i_waddr (w_waddr),
        .i_wdata (w_len_sat),
        .i_raddr (w_raddr),
        .o_rdata (w_len_rd)
    );

    kesm_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_code (
        .i_clk   (i_clk),
        .i_we    (w_whdr),
        .i_waddr (w_waddr),
        .i_wdata (i_item.entry_code),
        .i_raddr (w_raddr),
        .o_rdata (w_code_rd)
    );

    kesm_scan #(.ENTRIES(ENTRIES), .MAX_SEQ_LEN(MAX_SEQ_LEN)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_scan_start),
        .i_len       (w_scan_len),
        .i_buf       (w_scan_buf),
        .o_raddr     (w_scan_addr),
        .i_row_len   (w_row_len),
        .i_row_bytes (w_row_bytes),
        .o_done      (w_scan_done),
        .o_flags     (w_flags),
        .o_hit       (w_hit)
    );

    // Scan launch: stale prefix plus new byte, or the match buffer
    always_comb begin
        w_scan_start = 1'b0;
        w_scan_len   = SW'(r_mc);
        w_scan_buf   = r_buf;
        if (r_state == S_IDLEB && r_stale_act) begin
            w_scan_start = 1'b1;
            w_scan_len   = SW'(r_stale_len) + SW'(1);
            for (int i = 0; i < MAX_SEQ_LEN; i++) begin
                w_scan_buf[i] = (LW'(i) < r_stale_len) ? r_stale[i] : r_cur;
            end
        end else if (r_state == S_EVAL) begin
            w_scan_start = 1'b1;
        end
    end

    // Saturating tick counters
    assign n_age   = (r_age == TICK_MAX) ? r_age : r_age + 16'd1;
    assign n_timer = (r_timer == TICK_MAX) ? r_timer : r_timer + 16'd1;

    // Result queue handshake
    assign w_push      = (r_state == S_PUSH) && (r_res_n != 2'd0);
    assign w_push_last = (2'(r_push_i) + 2'd1 == r_res_n);
    assign w_pop       = o_tvalid && i_tready;
    assign o_tvalid    = (r_q_cnt != 3'd0);
    assign o_tdata     = r_q_val[r_q_rp];
    assign o_tuser     = r_q_kind[r_q_rp];
    assign o_tlast     = r_q_last[r_q_rp];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FETCH;
            r_phase      <= PH_IDLE;
            r_mc         <= '0;
            r_timer      <= '0;
            r_pend_code  <= '0;
            r_pend_single <= 1'b0;
            r_stale_len  <= '0;
            r_age        <= '0;
            r_stale_act  <= 1'b0;
            r_wait_ticks <= WAIT_TICKS_RST;
            r_gw_ticks   <= GW_TICKS_RST;
            r_res_n      <= '0;
            r_push_i     <= 1'b0;
            r_valid      <= '0;
            r_vld_rd     <= 1'b0;
            r_q_wp       <= '0;
            r_q_rp       <= '0;
            r_q_cnt      <= '0;
        end else begin
            r_vld_rd <= r_valid[w_raddr];
            if (w_whdr) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WAIT_TICKS) begin
                    r_wait_ticks <= i_cfg_data;
                end else if (i_cfg_idx == CFG_GW_TICKS) begin
                    r_gw_ticks <= i_cfg_data;
                end
            end

            // Result queue
            if (w_push) begin
                r_q_kind[r_q_wp] <= r_res_kind[r_push_i];
                r_q_val[r_q_wp]  <= r_res_val[r_push_i];
                r_q_last[r_q_wp] <= w_push_last;
                r_q_wp           <= r_q_wp + 2'd1;
            end
            if (w_pop) begin
                r_q_rp <= r_q_rp + 2'd1;
            end
            r_q_cnt <= r_q_cnt + 3'(w_push) - 3'(w_pop);

            case (r_state)
                S_FETCH: begin
                    if (w_take) begin
                        r_res_n <= '0;
                        case (i_item.cmd)
                            CMD_KEY: begin
                                if (r_phase == PH_IDLE) begin
                                    r_cur   <= i_item.data_byte;
                                    r_state <= S_IDLEB;
                                end else if (r_phase != PH_DROP) begin
                                    if (32'(r_mc) < MAX_SEQ_LEN) begin
                                        r_buf[r_mc[IW-1:0]] <= i_item.data_byte;
                                        r_mc <= r_mc + LW'(1);
                                    end
                                    r_state <= S_EVAL;
                                end
                            end
                            CMD_TICK: begin
                                if (r_phase == PH_WAIT && n_timer >= r_wait_ticks) begin
                                    // Time out: latch prefix, open window
                                    r_stale      <= r_buf;
                                    r_stale_len  <= r_mc;
                                    r_age        <= '0;
                                    r_stale_act  <= 1'b1;
                                    r_fin_single <= r_pend_single;
                                    r_fin_code   <= r_pend_code;
                                    r_state      <= S_FIN;
                                end else if (r_stale_act) begin
                                    // Age the garbage window
                                    r_age <= n_age;
                                    if (n_age >= r_gw_ticks) begin
                                        r_stale_act <= 1'b0;
                                    end
                                end
                                if (r_phase == PH_DROP) begin
                                    r_phase <= PH_IDLE;
                                end else if (r_phase == PH_WAIT) begin
                                    r_timer <= n_timer;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_IDLEB: begin
                    if (r_stale_act) begin
                        r_stale_act <= 1'b0;
                        r_ctx_stale <= 1'b1;
                        r_state     <= S_SCAN;
                    end else begin
                        r_buf[0] <= r_cur;
                        r_mc     <= LW'(1);
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_ctx_stale <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_scan_done) begin
                        if (r_ctx_stale) begin
                            if (w_flags.exact != 2'd0 || w_flags.partial) begin
                                // Late byte of a timed-out sequence
                                if (r_res_n != 2'd2) begin
                                    r_res_kind[r_res_n[0]] <= KIND_NULL;
                                    r_res_val[r_res_n[0]]  <= '0;
                                    r_res_n <= r_res_n + 2'd1;
                                end
                                r_phase <= PH_DROP;
                                r_mc    <= '0;
                                r_state <= S_PUSH;
                            end else begin
                                r_buf[0] <= r_cur;
                                r_mc     <= LW'(1);
                                r_state  <= S_EVAL;
                            end
                        end else if (w_flags.partial) begin
                            if (w_flags.exact == 2'd0) begin
                                r_phase <= PH_COLLECT;
                                r_state <= S_PUSH;
                            end else begin
                                r_phase       <= PH_WAIT;
                                r_timer       <= '0;
                                r_pend_single <= (w_flags.exact == 2'd1);
                                if (w_flags.exact == 2'd1) begin
                                    r_code_wait <= 1'b1;
                                    r_state     <= S_CODE;
                                end else begin
                                    r_pend_code <= '0;
                                    r_state     <= S_PUSH;
                                end
                            end
                        end else if (w_flags.exact == 2'd1) begin
                            r_code_wait <= 1'b0;
                            r_state     <= S_CODE;
                        end else begin
                            r_fin_single <= 1'b0;
                            r_fin_code   <= '0;
                            r_state      <= S_FIN;
                        end
                    end
                end
                S_CODE: begin
                    r_state <= S_CODE2;
                end
                S_CODE2: begin
                    if (r_code_wait) begin
                        r_pend_code <= w_code_rd;
                        r_state     <= S_PUSH;
                    end else begin
                        r_fin_single <= 1'b1;
                        r_fin_code   <= w_code_rd;
                        r_state      <= S_FIN;
                    end
                end
                S_FIN: begin
                    // End the sequence; two failed bytes replay the second
                    r_phase <= PH_IDLE;
                    r_mc    <= '0;
                    if (r_res_n != 2'd2) begin
                        r_res_n <= r_res_n + 2'd1;
                        if (r_fin_single) begin
                            r_res_kind[r_res_n[0]] <= KIND_CODE;
                            r_res_val[r_res_n[0]]  <= r_fin_code;
                        end else if (r_mc == LW'(1) || r_mc == LW'(2)) begin
                            r_res_kind[r_res_n[0]] <= KIND_RAW;
                            r_res_val[r_res_n[0]]  <= {8'd0, r_buf[0]};
                        end else begin
                            r_res_kind[r_res_n[0]] <= KIND_UNDEF;
                            r_res_val[r_res_n[0]]  <= '0;
                        end
                    end
                    if (!r_fin_single && r_mc == LW'(2)) begin
                        r_cur   <= r_buf[1];
                        r_state <= S_IDLEB;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_res_n == 2'd0 || w_push_last) begin
                        r_push_i <= 1'b0;
                        r_state  <= S_FETCH;
                    end else begin
                        r_push_i <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_FETCH;
                end
            endcase
        end
    end
endmodule
